// ===== hdl/isk_pkg.sv =====
// Shared types and constants for the insertion sort key core.
// No dependencies.
`default_nettype none
package isk_pkg;

  localparam int ISK_MAX_KEYS = 32;
  localparam int ISK_KEY_W    = 8;
  localparam int ISK_TAG_W    = 6;

  // One stored entry: sort key plus the record tag that rides with it.
  typedef struct packed {
    logic [ISK_KEY_W-1:0] key;
    logic [ISK_TAG_W-1:0] tag;
  } isk_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert new_item at its sorted place
    logic drain;  // shift the whole chain one cell toward cell 0
  } isk_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/insertion_sort_keys_core.sv =====
// Top level of the insertion sort key core: control, fill count, output register.
// Depends on isk_pkg and isk_cell.
`default_nettype none
// Stable insertion sorter for byte keys with 6-bit record tags. Keys enter on
// the in_ stream, one beat per cycle, and are placed at once into a chain of
// MAX_KEYS cells that compare against the new key in parallel and shift the
// larger entries up by one. Equal keys keep arrival order. The beat with
// in_tlast set is inserted too, and then the chain drains through cell 0: one
// out_ beat per stored key, ascending, out_tlast on the final one. While the
// run drains, in_tready stays low, also through any out_tready stalls;
// otherwise a key is taken every cycle. Keys that arrive while all
// MAX_KEYS cells are full are dropped, and every beat of that run then carries
// the overflow bit. After the final beat is loaded the store is empty again.
module insertion_sort_keys_core #(
  parameter int MAX_KEYS = isk_pkg::ISK_MAX_KEYS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] key, [13:8] tag, [15:14] zero
  input  wire logic        in_tlast,   // last key of the set
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] key_out, [13:8] tag_out, [14] overflow, [15] zero
  output logic             out_tlast   // final beat of the sorted run
);
  import isk_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_KEYS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Control state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drain_r, drain_nxt;
  logic             drop_r, drop_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  isk_item_t        out_item_r, out_item_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  isk_ctl_t         ctl;
  isk_item_t        new_item;
  logic             in_beat;
  logic             drain_step;

  // Chain wiring
  isk_item_t        cell_item [MAX_KEYS];
  logic [MAX_KEYS-1:0] cell_gt;
  logic [MAX_KEYS-1:0] cell_occ;

  assign in_tready  = !drain_r;
  assign in_beat    = in_tvalid && in_tready;
  assign new_item   = '{key: in_tdata[7:0], tag: in_tdata[13:8]};
  // One drain beat whenever the output register is free or being emptied.
  assign drain_step = drain_r && (!out_valid_r || out_tready);

  assign ctl = '{ins: in_beat && (cnt_r < CNT_FULL), drain: drain_step};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
      isk_item_t left_item;
      isk_item_t right_item;
      logic      left_gt;

      assign cell_occ[gi] = (CNT_W'(gi) < cnt_r);

      if (gi == 0) begin : g_first
        assign left_item = new_item;
        assign left_gt   = 1'b0;
      end else begin : g_mid
        assign left_item = cell_item[gi-1];
        assign left_gt   = cell_gt[gi-1];
      end

      if (gi == MAX_KEYS - 1) begin : g_last
        assign right_item = cell_item[gi];
      end else begin : g_inner
        assign right_item = cell_item[gi+1];
      end

      isk_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_item   (new_item),
        .left_item  (left_item),
        .right_item (right_item),
        .left_gt    (left_gt),
        .occ        (cell_occ[gi]),
        .item       (cell_item[gi]),
        .gt         (cell_gt[gi])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt       = cnt_r;
    drain_nxt     = drain_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_beat) begin
      if (ctl.ins) begin
        cnt_nxt = cnt_r + CNT_ONE;
      end else begin
        drop_nxt = 1'b1;
      end
      if (in_tlast) begin
        drain_nxt = 1'b1;
      end
    end

    if (drain_step) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = cell_item[0];
      out_last_nxt  = (cnt_r == CNT_ONE);
      out_ovf_nxt   = drop_r;
      cnt_nxt       = cnt_r - CNT_ONE;
      if (cnt_r == CNT_ONE) begin
        drain_nxt = 1'b0;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drain_r     <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ovf_r, out_item_r.tag, out_item_r.key};
  assign out_tlast  = out_last_r;

  // A run never drains from an empty store.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (cnt_r != '0))
    else $error("drain with empty store");

  // Fill count never passes capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("fill count above capacity");

  // A key offered to a full store sets the drop flag.
  a_drop_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && !in_tlast && (cnt_r == CNT_FULL)) |=> drop_r)
    else $error("dropped key not flagged");

  // The final drain step ends the drain and loads the last beat.
  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_step && (cnt_r == CNT_ONE)) |=> (!drain_r && out_valid_r && out_last_r))
    else $error("drain continues past final beat");

endmodule
`default_nettype wire

// ===== hdl/isk_cell.sv =====
// One cell of the insertion chain: holds one key/tag entry.
// Depends on isk_pkg.
`default_nettype none
module isk_cell (
  input  wire logic              clk,
  input  wire isk_pkg::isk_ctl_t  ctl,
  input  wire isk_pkg::isk_item_t new_item,
  input  wire isk_pkg::isk_item_t left_item,
  input  wire isk_pkg::isk_item_t right_item,
  input  wire logic              left_gt,
  input  wire logic              occ,
  output isk_pkg::isk_item_t     item,
  output logic                   gt
);
  import isk_pkg::*;

  isk_item_t item_r;
  isk_item_t item_nxt;

  // Empty cells count as greater; strict compare keeps equal keys in arrival order.
  assign gt   = !occ || (item_r.key > new_item.key);
  assign item = item_r;

  always_comb begin
    item_nxt = item_r;
    if (ctl.drain) begin
      item_nxt = right_item;
    end else if (ctl.ins && gt) begin
      item_nxt = left_gt ? left_item : new_item;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule
`default_nettype wire
